>>> sv/fchc_pkg.sv
// Package for the fan curve hysteresis controller.
// Holds widths, reset values, register indexes, sequencer states and shared types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package fchc_pkg;

  localparam int TempW      = 17;
  localparam int DutyW      = 8;
  localparam int ModeW      = 2;
  localparam int MaxPoints  = 5;
  localparam int DefPoints  = 5;
  localparam int IdxW       = $clog2(MaxPoints);
  localparam int DutiesW    = MaxPoints * DutyW;
  localparam int NumW       = TempW + DutyW;
  localparam int QuotW      = DutyW;
  localparam int CfgAddrW   = 3;
  localparam int CfgDataW   = DutiesW;
  localparam int InDataW    = 40;
  localparam int OutDataW   = 16;

  localparam logic [TempW-1:0]   HystRst   = TempW'(6000);
  localparam logic [TempW-1:0]   Temp0Rst  = TempW'(30000);
  localparam logic [TempW-1:0]   Temp1Rst  = TempW'(45000);
  localparam logic [TempW-1:0]   Temp2Rst  = TempW'(55000);
  localparam logic [TempW-1:0]   Temp3Rst  = TempW'(67000);
  localparam logic [TempW-1:0]   Temp4Rst  = TempW'(75000);
  localparam logic [DutiesW-1:0] DutiesRst = {8'd255, 8'd169, 8'd125, 8'd100, 8'd56};

  localparam logic [ModeW-1:0] ModeFull   = 2'd0;
  localparam logic [ModeW-1:0] ModeManual = 2'd1;

  typedef enum logic [CfgAddrW-1:0] {
    REG_HYST   = 3'd0,
    REG_TEMP0  = 3'd1,
    REG_TEMP1  = 3'd2,
    REG_TEMP2  = 3'd3,
    REG_TEMP3  = 3'd4,
    REG_TEMP4  = 3'd5,
    REG_DUTIES = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_SEARCH,
    ST_MUL,
    ST_DIV,
    ST_FINISH
  } st_t;

  typedef logic [MaxPoints-1:0][TempW-1:0] temp_arr_t;
  typedef logic [MaxPoints-1:0][DutyW-1:0] duty_arr_t;

  typedef struct packed {
    logic [TempW-1:0] hyst;
    temp_arr_t        temps;
    duty_arr_t        duties;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

>>> sv/fan_curve_hysteresis_controller_top.sv
// Fan curve controller with hysteresis: sequencer, curve search and output register.
// The serial segment search and the restoring divider set the time from request to result
// when interpolating; a request on the clamped ends skips both.
// One request is in work at a time; in_tready returns the cycle after the result loads.
// Synchronous active-low reset restores the register defaults and clears the
// last-change temperature. Depends on fchc_pkg, fchc_cfg and fchc_div.
`default_nettype none
module fan_curve_hysteresis_controller_top
  import fchc_pkg::*;
#(
  parameter int CURVE_POINTS = DefPoints
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // gpu_temp [16:0], junction_temp [33:17], fan_mode_now [35:34]
  input  wire logic [InDataW-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // duty_write [0], duty_value [8:1], go_manual [9]
  output logic [OutDataW-1:0]      out_tdata,
  input  wire logic                cfg_we,
  input  wire logic [CfgAddrW-1:0] cfg_addr,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(CURVE_POINTS - 1);

  cfg_t             cfg;
  div_stat_t        div_stat;
  logic [QuotW-1:0] quot;
  logic             div_start;
  logic [NumW-1:0]  div_num;
  logic [TempW-1:0] div_den;

  st_t              state_r, state_nxt;
  logic [TempW-1:0] avg_r, avg_nxt;
  logic [TempW-1:0] lct_r, lct_nxt;
  logic             write_r, write_nxt;
  logic             gman_r, gman_nxt;
  logic [IdxW-1:0]  idx_r, idx_nxt;
  logic [TempW-1:0] lt_r, lt_nxt;
  logic [TempW-1:0] ht_r, ht_nxt;
  logic [DutyW-1:0] ld_r, ld_nxt;
  logic [DutyW-1:0] hd_r, hd_nxt;
  logic             neg_r, neg_nxt;
  logic [DutyW-1:0] duty_r, duty_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;

  logic [TempW-1:0] in_gpu;
  logic [TempW-1:0] in_junc;
  logic [ModeW-1:0] in_mode;
  logic [TempW-1:0] in_avg;
  logic [TempW:0]   avg_hyst;
  logic             in_write;
  logic [TempW-1:0] seg_diff;
  logic [DutyW:0]   duty_delta;
  logic [DutyW-1:0] delta_mag;
  logic [DutyW+1:0] interp;
  logic [DutyW+1:0] quot_signed;

  fchc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fchc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (quot)
  );

  assign in_gpu   = in_tdata[TempW-1:0];
  assign in_junc  = in_tdata[2*TempW-1:TempW];
  assign in_mode  = in_tdata[2*TempW+ModeW-1:2*TempW];
  assign in_avg   = {1'b0, in_gpu[TempW-1:1]} + {1'b0, in_junc[TempW-1:1]};
  assign avg_hyst = {1'b0, in_avg} + {1'b0, cfg.hyst};
  assign in_write = (in_gpu >= lct_r) || (avg_hyst <= {1'b0, lct_r}) ||
                    (in_mode == ModeFull);

  assign seg_diff    = avg_r - lt_r;
  assign duty_delta  = {1'b0, hd_r} - {1'b0, ld_r};
  assign delta_mag   = duty_delta[DutyW] ? DutyW'(-duty_delta) : duty_delta[DutyW-1:0];
  assign div_num     = {{DutyW{1'b0}}, seg_diff} * {{TempW{1'b0}}, delta_mag};
  assign div_den     = ht_r - lt_r;
  assign quot_signed = neg_r ? -{2'b00, quot} : {2'b00, quot};
  assign interp      = {2'b00, ld_r} + quot_signed;

  always_comb begin
    state_nxt     = state_r;
    avg_nxt       = avg_r;
    lct_nxt       = lct_r;
    write_nxt     = write_r;
    gman_nxt      = gman_r;
    idx_nxt       = idx_r;
    lt_nxt        = lt_r;
    ht_nxt        = ht_r;
    ld_nxt        = ld_r;
    hd_nxt        = hd_r;
    neg_nxt       = neg_r;
    duty_nxt      = duty_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    in_tready     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          avg_nxt   = in_avg;
          write_nxt = in_write;
          gman_nxt  = (in_mode != ModeManual);
          if (in_write) begin
            lct_nxt = in_avg;
          end
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (avg_r <= cfg.temps[0]) begin
          duty_nxt  = cfg.duties[0];
          state_nxt = ST_FINISH;
        end else if (avg_r >= cfg.temps[LastIdx]) begin
          duty_nxt  = cfg.duties[LastIdx];
          state_nxt = ST_FINISH;
        end else begin
          idx_nxt   = IdxW'(1);
          lt_nxt    = cfg.temps[0];
          ld_nxt    = cfg.duties[0];
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if ((avg_r < cfg.temps[idx_r]) || (idx_r >= LastIdx)) begin
          ht_nxt    = cfg.temps[idx_r];
          hd_nxt    = cfg.duties[idx_r];
          state_nxt = ST_MUL;
        end else begin
          lt_nxt  = cfg.temps[idx_r];
          ld_nxt  = cfg.duties[idx_r];
          idx_nxt = idx_r + IdxW'(1);
        end
      end
      ST_MUL: begin
        neg_nxt   = duty_delta[DutyW];
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (interp[DutyW+1]) begin
            duty_nxt = '0;
          end else if (interp[DutyW]) begin
            duty_nxt = '1;
          end else begin
            duty_nxt = interp[DutyW-1:0];
          end
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OutDataW-DutyW-2){1'b0}}, gman_r, duty_r, write_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lct_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lct_r       <= lct_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    avg_r      <= avg_nxt;
    write_r    <= write_nxt;
    gman_r     <= gman_nxt;
    idx_r      <= idx_nxt;
    lt_r       <= lt_nxt;
    ht_r       <= ht_nxt;
    ld_r       <= ld_nxt;
    hd_r       <= hd_nxt;
    neg_r      <= neg_nxt;
    duty_r     <= duty_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

>>> sv/fchc_cfg.sv
// Configuration register file of the fan curve controller.
// Holds the hysteresis, the curve temperatures and the packed curve duties.
// Depends on fchc_pkg.
`default_nettype none
module fchc_cfg
  import fchc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgAddrW-1:0] cfg_addr,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_HYST:   cfg_nxt.hyst     = cfg_wdata[TempW-1:0];
        REG_TEMP0:  cfg_nxt.temps[0] = cfg_wdata[TempW-1:0];
        REG_TEMP1:  cfg_nxt.temps[1] = cfg_wdata[TempW-1:0];
        REG_TEMP2:  cfg_nxt.temps[2] = cfg_wdata[TempW-1:0];
        REG_TEMP3:  cfg_nxt.temps[3] = cfg_wdata[TempW-1:0];
        REG_TEMP4:  cfg_nxt.temps[4] = cfg_wdata[TempW-1:0];
        REG_DUTIES: cfg_nxt.duties   = cfg_wdata[DutiesW-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hyst     <= HystRst;
      cfg_r.temps[0] <= Temp0Rst;
      cfg_r.temps[1] <= Temp1Rst;
      cfg_r.temps[2] <= Temp2Rst;
      cfg_r.temps[3] <= Temp3Rst;
      cfg_r.temps[4] <= Temp4Rst;
      cfg_r.duties   <= DutiesRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> sv/fchc_div.sv
// Shared restoring divider of the fan curve controller, one quotient bit a cycle.
// The quotient is known to stay below 2**QuotW, so the top bits start as remainder.
// Depends on fchc_pkg.
`default_nettype none
module fchc_div
  import fchc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NumW-1:0]  num,
  input  wire logic [TempW-1:0] den,
  output div_stat_t             stat,
  output logic      [QuotW-1:0] quot
);

  localparam int CntW = $clog2(QuotW + 1);

  logic [TempW-1:0] rem_r, rem_nxt;
  logic [QuotW-1:0] lo_r, lo_nxt;
  logic [QuotW-1:0] q_r, q_nxt;
  logic [TempW-1:0] den_r, den_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [TempW:0]   trial;
  logic [TempW:0]   diff;

  assign trial = {rem_r, lo_r[QuotW-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num[NumW-1:QuotW];
      lo_nxt   = num[QuotW-1:0];
      den_nxt  = den;
      q_nxt    = '0;
      cnt_nxt  = CntW'(QuotW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      lo_nxt = {lo_r[QuotW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[TempW-1:0];
        q_nxt   = {q_r[QuotW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[TempW-1:0];
        q_nxt   = {q_r[QuotW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule
`default_nettype wire
